// ===== hdl/sonar_parking_beeper_core_defines.svh =====
`ifndef SONAR_PARKING_BEEPER_CORE_DEFINES_SVH
`define SONAR_PARKING_BEEPER_CORE_DEFINES_SVH

// Assertion helpers for the parking beeper core. They expect clk and arst_n in scope.

// The consequent must hold in the same cycle as the antecedent.
`define SPB_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/spb_pkg.sv =====
package spb_pkg;

	localparam int TIMER_WIDTH_DEF = 32;

	localparam int STAMP_W = 32;
	localparam int MS_W    = 32;
	localparam int SCALE_W = 16;
	localparam int DIST_W  = 24;
	localparam int MPC_W   = 6;
	localparam int IVAL_W  = 12;
	localparam int ZONE_W  = 2;
	localparam int FRAC_W  = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MPC   = 2'd3;

	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd1124;
	localparam logic [DIST_W-1:0]  FAR_RST   = 24'd15360;
	localparam logic [DIST_W-1:0]  NEAR_RST  = 24'd2560;
	localparam logic [MPC_W-1:0]   MPC_RST   = 6'd10;

	localparam logic [ZONE_W-1:0] ZONE_OFF  = 2'd0;
	localparam logic [ZONE_W-1:0] ZONE_CONT = 2'd1;
	localparam logic [ZONE_W-1:0] ZONE_BEEP = 2'd2;

	localparam logic [DIST_W-1:0] DIST_MAX  = '1;
	localparam logic [IVAL_W-1:0] IVAL_MAX  = '1;
	localparam logic [IVAL_W-1:0] IVAL_OFF  = 12'd0;
	localparam logic [IVAL_W-1:0] IVAL_CONT = 12'd1;

	typedef struct packed {
		logic [STAMP_W-1:0] rise_stamp;
		logic [STAMP_W-1:0] fall_stamp;
		logic               rise_seen;
		logic               fall_seen;
		logic [MS_W-1:0]    now_ms;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_q8;
		logic              reading_ok;
		logic [ZONE_W-1:0] zone;
		logic [IVAL_W-1:0] beep_interval_ms;
		logic              buzzer_level;
		logic              toggled;
	} out_item_t;

endpackage

// ===== hdl/sonar_parking_beeper_core.sv =====
// Parking sensor core: turns one echo measurement into a distance and a buzzer command.
// Input channel (in_valid/in_ready/in_data) carries the two capture stamps, their
// seen flags and the current millisecond time. Output channel (out_valid/out_ready/
// out_data) returns one result per input transfer: distance in Q8 cm, zone, beep
// interval, buzzer level and a toggle flag.
// Both products are formed on one shift-add multiplier, one multiplier bit per cycle:
// first the distance scale, then the beep interval when in the beeping zone; a failed
// capture skips both products. in_ready rises again in the cycle after the result is
// loaded. The output register holds a finished result while the next item is accepted
// and worked on; if the receiver still stalls when the next result is done, the core
// waits with in_ready low.
// The user must write the registers through cfg_we/cfg_index/cfg_data only while the
// core is idle; the core leaves this unchecked.
// Reset loads the default register values, turns the buzzer off, clears the last
// toggle time and empties the output register.
`include "sonar_parking_beeper_core_defines.svh"

module sonar_parking_beeper_core #(
	parameter int TIMER_WIDTH = spb_pkg::TIMER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  spb_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output spb_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [spb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int PROD_W = TIMER_WIDTH + spb_pkg::SCALE_W;
	// Keep at least one bit above the saturation point of the distance.
	localparam int SAT_LO = spb_pkg::DIST_W + spb_pkg::FRAC_W;
	localparam int ACC_W  = (PROD_W > SAT_LO) ? PROD_W : SAT_LO + 1;
	localparam int IVAL_LO = spb_pkg::IVAL_W + spb_pkg::FRAC_W;
	localparam int CNT_W  = $clog2(spb_pkg::SCALE_W + 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_MUL_DIST = 3'd1;
	localparam logic [2:0] ST_ZONE     = 3'd2;
	localparam logic [2:0] ST_MUL_IVAL = 3'd3;
	localparam logic [2:0] ST_TOGGLE   = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;

	logic [2:0]                        state_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [spb_pkg::SCALE_W-1:0]       scale_q;
	logic [spb_pkg::DIST_W-1:0]        far_q;
	logic [spb_pkg::DIST_W-1:0]        near_q;
	logic [spb_pkg::MPC_W-1:0]         mpc_q;
	logic                              buzzer_q;
	logic [spb_pkg::MS_W-1:0]          last_toggle_q;
	logic                              out_valid_q;

	logic [ACC_W-1:0]                  acc_q;
	logic [ACC_W-1:0]                  mcand_q;
	logic [spb_pkg::SCALE_W-1:0]       mplier_q;
	logic [spb_pkg::MS_W-1:0]          now_q;
	logic                              ok_q;
	logic [spb_pkg::DIST_W-1:0]        dist_q;
	logic [spb_pkg::ZONE_W-1:0]        zone_q;
	logic [spb_pkg::IVAL_W-1:0]        ival_q;
	logic                              tog_q;
	spb_pkg::out_item_t                out_q;

	logic [TIMER_WIDTH-1:0]            delta;
	logic [ACC_W-1:0]                  acc_sum;
	logic [spb_pkg::DIST_W-1:0]        dist_w;
	logic [spb_pkg::IVAL_W-1:0]        ival_w;
	logic [spb_pkg::MS_W-1:0]          elapsed;
	logic                              in_ok;
	logic                              zone_off;
	logic                              zone_cont;
	logic                              do_toggle;
	logic                              out_load;

	assign in_ok = in_data.rise_seen & in_data.fall_seen;
	assign delta = in_data.fall_stamp[TIMER_WIDTH-1:0] - in_data.rise_stamp[TIMER_WIDTH-1:0];

	// Shared shift-add unit: adds the shifted multiplicand when the current bit is set.
	assign acc_sum = acc_q + (mplier_q[0] ? mcand_q : '0);

	assign dist_w = (acc_q[ACC_W-1:SAT_LO] != '0) ? spb_pkg::DIST_MAX
		: acc_q[SAT_LO-1:spb_pkg::FRAC_W];
	assign ival_w = (acc_q[ACC_W-1:IVAL_LO] != '0) ? spb_pkg::IVAL_MAX
		: acc_q[IVAL_LO-1:spb_pkg::FRAC_W];

	assign zone_off  = !ok_q || (dist_w > far_q);
	assign zone_cont = dist_w <= near_q;

	assign elapsed   = now_q - last_toggle_q;
	assign do_toggle = (ival_w > spb_pkg::IVAL_CONT)
		&& (elapsed >= {{(spb_pkg::MS_W - spb_pkg::IVAL_W){1'b0}}, ival_w});

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			scale_q       <= spb_pkg::SCALE_RST;
			far_q         <= spb_pkg::FAR_RST;
			near_q        <= spb_pkg::NEAR_RST;
			mpc_q         <= spb_pkg::MPC_RST;
			buzzer_q      <= 1'b0;
			last_toggle_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					spb_pkg::CFG_SCALE: scale_q <= cfg_data[spb_pkg::SCALE_W-1:0];
					spb_pkg::CFG_FAR:   far_q   <= cfg_data[spb_pkg::DIST_W-1:0];
					spb_pkg::CFG_NEAR:  near_q  <= cfg_data[spb_pkg::DIST_W-1:0];
					spb_pkg::CFG_MPC:   mpc_q   <= cfg_data[spb_pkg::MPC_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= CNT_W'(spb_pkg::SCALE_W);
						state_q <= in_ok ? ST_MUL_DIST : ST_ZONE;
					end
				end
				ST_MUL_DIST: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_ZONE;
					end
				end
				ST_ZONE: begin
					if (zone_off) begin
						buzzer_q <= 1'b0;
						state_q  <= ST_DONE;
					end else if (zone_cont) begin
						buzzer_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						cnt_q   <= CNT_W'(spb_pkg::MPC_W);
						state_q <= ST_MUL_IVAL;
					end
				end
				ST_MUL_IVAL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_TOGGLE;
					end
				end
				ST_TOGGLE: begin
					if (do_toggle) begin
						buzzer_q      <= ~buzzer_q;
						last_toggle_q <= now_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q    <= '0;
				mcand_q  <= ACC_W'(delta);
				mplier_q <= scale_q;
				now_q    <= in_data.now_ms;
				ok_q     <= in_ok;
			end
			ST_MUL_DIST, ST_MUL_IVAL: begin
				acc_q    <= acc_sum;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			ST_ZONE: begin
				dist_q <= dist_w;
				tog_q  <= 1'b0;
				if (zone_off) begin
					zone_q <= spb_pkg::ZONE_OFF;
					ival_q <= spb_pkg::IVAL_OFF;
				end else if (zone_cont) begin
					zone_q <= spb_pkg::ZONE_CONT;
					ival_q <= spb_pkg::IVAL_CONT;
				end else begin
					zone_q   <= spb_pkg::ZONE_BEEP;
					acc_q    <= '0;
					mcand_q  <= ACC_W'(dist_w);
					mplier_q <= spb_pkg::SCALE_W'(mpc_q);
				end
			end
			ST_TOGGLE: begin
				ival_q <= ival_w;
				tog_q  <= do_toggle;
			end
			ST_DONE: begin
				if (out_load) begin
					out_q.distance_q8      <= dist_q;
					out_q.reading_ok       <= ok_q;
					out_q.zone             <= zone_q;
					out_q.beep_interval_ms <= ival_q;
					out_q.buzzer_level     <= buzzer_q;
					out_q.toggled          <= tog_q;
				end
			end
			default: ;
		endcase
	end

	`SPB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"core stayed ready after an input transfer")

	`SPB_ASSERT_IMPLY(a_off_zone_silent,
		out_valid && (out_data.zone == spb_pkg::ZONE_OFF),
		(out_data.beep_interval_ms == spb_pkg::IVAL_OFF) && !out_data.buzzer_level
		&& !out_data.toggled,
		"off zone result drives the buzzer or reports an interval")

	`SPB_ASSERT_IMPLY(a_toggle_only_beeping, out_valid && out_data.toggled,
		(out_data.zone == spb_pkg::ZONE_BEEP)
		&& (out_data.beep_interval_ms > spb_pkg::IVAL_CONT),
		"toggle reported outside the beeping zone")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_HALF      = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_MAX    = 10;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	spb_pkg::in_item_t              in_data;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	spb_pkg::out_item_t             out_data;
	logic                           cfg_we;
	logic [spb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [spb_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the registers and of the buzzer state.
	logic [spb_pkg::SCALE_W-1:0] scale_reg;
	logic [spb_pkg::DIST_W-1:0]  far_reg;
	logic [spb_pkg::DIST_W-1:0]  near_reg;
	logic [spb_pkg::MPC_W-1:0]   mpc_reg;
	logic [spb_pkg::MS_W-1:0]    last_toggle;
	logic                        buzzer;

	spb_pkg::out_item_t       pending_readings[$];
	int                       bad_results = 0;
	int                       cycle_count = 0;
	int                       send_idle_pct = 0;
	int                       recv_idle_pct = 20;
	logic [spb_pkg::MS_W-1:0] now_clock;

	sonar_parking_beeper_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic spb_pkg::out_item_t predict_reading(spb_pkg::in_item_t it);
		spb_pkg::out_item_t                         r;
		logic [spb_pkg::STAMP_W-1:0]                width_ticks;
		logic [47:0]                                dist_full;
		logic [spb_pkg::DIST_W+spb_pkg::MPC_W-1:0]  ival_full;
		logic [spb_pkg::DIST_W-1:0]                 dist_val;
		logic [spb_pkg::IVAL_W-1:0]                 ival;
		logic [spb_pkg::MS_W-1:0]                   elapsed;
		r = '0;
		dist_val = '0;
		r.reading_ok = it.rise_seen & it.fall_seen;
		if (r.reading_ok) begin
			width_ticks = it.fall_stamp - it.rise_stamp;
			dist_full = (48'(width_ticks) * 48'(scale_reg)) >> spb_pkg::FRAC_W;
			dist_val = (dist_full > 48'(spb_pkg::DIST_MAX)) ? spb_pkg::DIST_MAX
				: dist_full[spb_pkg::DIST_W-1:0];
		end
		r.distance_q8 = dist_val;
		// The far test wins when the near limit is not below the far limit.
		if (!r.reading_ok || dist_val > far_reg) begin
			r.zone = spb_pkg::ZONE_OFF;
			r.beep_interval_ms = spb_pkg::IVAL_OFF;
			buzzer = 1'b0;
		end else if (dist_val <= near_reg) begin
			r.zone = spb_pkg::ZONE_CONT;
			r.beep_interval_ms = spb_pkg::IVAL_CONT;
			buzzer = 1'b1;
		end else begin
			r.zone = spb_pkg::ZONE_BEEP;
			ival_full = (30'(dist_val) * 30'(mpc_reg)) >> spb_pkg::FRAC_W;
			ival = (ival_full > 30'(spb_pkg::IVAL_MAX)) ? spb_pkg::IVAL_MAX
				: ival_full[spb_pkg::IVAL_W-1:0];
			r.beep_interval_ms = ival;
			// An interval of 0 or 1 never toggles; the saturated value is used for timing.
			if (ival > spb_pkg::IVAL_CONT) begin
				elapsed = it.now_ms - last_toggle;
				if (elapsed >= 32'(ival)) begin
					last_toggle = it.now_ms;
					buzzer = ~buzzer;
					r.toggled = 1'b1;
				end
			end
		end
		r.buzzer_level = buzzer;
		return r;
	endfunction

	function automatic spb_pkg::in_item_t echo(logic [spb_pkg::STAMP_W-1:0] rise,
			logic [spb_pkg::STAMP_W-1:0] fall, logic rs, logic fs,
			logic [spb_pkg::MS_W-1:0] now);
		spb_pkg::in_item_t it;
		it.rise_stamp = rise;
		it.fall_stamp = fall;
		it.rise_seen = rs;
		it.fall_seen = fs;
		it.now_ms = now;
		return it;
	endfunction

	// Echo width in ticks that lands near a given Q8 distance under the current scale.
	function automatic logic [spb_pkg::STAMP_W-1:0] ticks_for(logic [31:0] target);
		if (scale_reg == '0)
			return $urandom();
		return 32'(((64'(target) << spb_pkg::FRAC_W) + 64'($urandom_range(scale_reg - 1)))
			/ 64'(scale_reg));
	endfunction

	// All driving tasks start and end at a falling edge.
	task automatic send_item(input spb_pkg::in_item_t it);
		int gap;
		in_data = it;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_readings.push_back(predict_reading(it));
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_readings.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [spb_pkg::CFG_IDX_W-1:0] idx,
			input logic [spb_pkg::CFG_DATA_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			spb_pkg::CFG_SCALE: scale_reg = value[spb_pkg::SCALE_W-1:0];
			spb_pkg::CFG_FAR:   far_reg = value[spb_pkg::DIST_W-1:0];
			spb_pkg::CFG_NEAR:  near_reg = value[spb_pkg::DIST_W-1:0];
			spb_pkg::CFG_MPC:   mpc_reg = value[spb_pkg::MPC_W-1:0];
			default: ;
		endcase
	endtask

	// Upper bits of the narrow registers carry noise to exercise the width masking.
	task automatic set_config(input logic [spb_pkg::SCALE_W-1:0] scale,
			input logic [spb_pkg::DIST_W-1:0] far, input logic [spb_pkg::DIST_W-1:0] near,
			input logic [spb_pkg::MPC_W-1:0] mpc);
		wait_idle();
		write_reg(spb_pkg::CFG_SCALE, {8'($urandom()), scale});
		write_reg(spb_pkg::CFG_FAR, far);
		write_reg(spb_pkg::CFG_NEAR, near);
		write_reg(spb_pkg::CFG_MPC, {18'($urandom()), mpc});
	endtask

	task automatic test_special_cases();
		send_item(echo($urandom(), $urandom(), 1'b0, 1'b1, 32'd5));
		send_item(echo($urandom(), $urandom(), 1'b1, 1'b0, 32'd6));
		send_item(echo($urandom(), $urandom(), 1'b0, 1'b0, 32'd7));
		send_item(echo(32'h1234_5678, 32'h1234_5678, 1'b1, 1'b1, 32'd8));
		// Fall stamp below rise stamp: the width wraps around.
		send_item(echo(32'hFFFF_FF00, 32'h0000_0100, 1'b1, 1'b1, 32'd9));
		send_item(echo(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd10));
		// Beeping at the default settings: interval is 257 ms.
		send_item(echo(32'd0, 32'd1500, 1'b1, 1'b1, 32'd100));
		send_item(echo(32'd0, 32'd1500, 1'b1, 1'b1, 32'd357));
		send_item(echo(32'd0, 32'd1500, 1'b1, 1'b1, 32'd613));
		send_item(echo(32'd0, 32'd1500, 1'b1, 1'b1, 32'd614));
		// Millisecond time wraps between toggles.
		send_item(echo(32'd7, 32'd1507, 1'b1, 1'b1, 32'hFFFF_FFF0));
		send_item(echo(32'd7, 32'd1507, 1'b1, 1'b1, 32'h0000_00F0));
		send_item(echo(32'd7, 32'd1507, 1'b1, 1'b1, 32'h0000_00F1));
		// Both sides of the near and far limits.
		send_item(echo(32'd100, 32'd683, 1'b1, 1'b1, 32'd300));
		send_item(echo(32'd100, 32'd684, 1'b1, 1'b1, 32'd301));
		send_item(echo(32'd100, 32'd3598, 1'b1, 1'b1, 32'd302));
		send_item(echo(32'd100, 32'd3599, 1'b1, 1'b1, 32'd303));
	endtask

	task automatic test_register_corners();
		set_config(16'd0, spb_pkg::FAR_RST, spb_pkg::NEAR_RST, spb_pkg::MPC_RST);
		send_item(echo(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'd400));
		// Largest scale and factor: the interval saturates at its maximum.
		set_config(16'hFFFF, spb_pkg::DIST_MAX, 24'd0, 6'd63);
		send_item(echo(32'd0, 32'h1000, 1'b1, 1'b1, last_toggle + 32'd4094));
		send_item(echo(32'd0, 32'h1000, 1'b1, 1'b1, last_toggle + 32'd4095));
		send_item(echo(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, last_toggle + 32'd9000));
		// A zero or unit interval inside the beeping zone never toggles.
		set_config(spb_pkg::SCALE_RST, spb_pkg::FAR_RST, 24'd0, 6'd0);
		send_item(echo(32'd0, 32'd1500, 1'b1, 1'b1, last_toggle + 32'd100000));
		wait_idle();
		write_reg(spb_pkg::CFG_MPC, 24'd1);
		send_item(echo(32'd0, 32'd70, 1'b1, 1'b1, last_toggle + 32'd100000));
		// Near limit above far limit.
		set_config(spb_pkg::SCALE_RST, 24'd2560, spb_pkg::DIST_MAX, spb_pkg::MPC_RST);
		send_item(echo(32'd0, 32'd1500, 1'b1, 1'b1, 32'd500));
		send_item(echo(32'd0, 32'd500, 1'b1, 1'b1, 32'd501));
		set_config(spb_pkg::SCALE_RST, 24'd0, 24'd0, spb_pkg::MPC_RST);
		send_item(echo(32'd0, 32'd0, 1'b1, 1'b1, 32'd600));
		send_item(echo(32'd0, 32'd1, 1'b1, 1'b1, 32'd601));
		set_config(spb_pkg::SCALE_RST, spb_pkg::FAR_RST, spb_pkg::NEAR_RST, spb_pkg::MPC_RST);
	endtask

	task automatic pick_config();
		logic [spb_pkg::DIST_W-1:0] lim;
		case ($urandom_range(7))
			0: set_config(spb_pkg::SCALE_RST, spb_pkg::FAR_RST, spb_pkg::NEAR_RST,
				spb_pkg::MPC_RST);
			1: set_config(16'hFFFF, spb_pkg::DIST_MAX, 24'd0, 6'd63);
			2: set_config(16'd0, 24'($urandom_range(0, 30000)), 24'($urandom_range(0, 3000)),
				6'($urandom_range(63)));
			3: set_config(spb_pkg::SCALE_RST, spb_pkg::FAR_RST, 24'($urandom_range(0, 600)),
				6'd0);
			4: begin
				lim = 24'($urandom_range(2000, 20000));
				set_config(16'($urandom_range(600, 2000)),
					24'(32'(lim) - $urandom_range(lim / 2)), lim,
					6'($urandom_range(63)));
			end
			default: begin
				lim = 24'($urandom_range(4000, 60000));
				set_config(16'($urandom_range(600, 2000)), lim, 24'($urandom_range(0, lim)),
					6'($urandom_range(63)));
			end
		endcase
	endtask

	task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
		spb_pkg::in_item_t           it;
		logic [31:0]                 target;
		logic [spb_pkg::STAMP_W-1:0] ticks;
		int                          roll;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 55 == 0)
				pick_config();
			else if (n == count / 2)
				wait_idle();
			roll = $urandom_range(99);
			if (roll < 3)
				now_clock = $urandom();
			else if (roll < 12)
				now_clock += $urandom_range(0, 5000);
			else
				now_clock += $urandom_range(0, 300);
			roll = $urandom_range(99);
			if (roll < 15)
				target = $urandom_range(0, near_reg);
			else if (roll < 80)
				target = $urandom_range(near_reg, far_reg);
			else if (roll < 92)
				target = far_reg + $urandom_range(0, far_reg / 4 + 64);
			else
				target = '0;
			ticks = (roll < 92) ? ticks_for(target) : 32'($urandom());
			it = echo($urandom(), '0, 1'b1, 1'b1, now_clock);
			it.fall_stamp = it.rise_stamp + ticks;
			roll = $urandom_range(99);
			if (roll < 8) begin
				it.rise_seen = 1'($urandom_range(1));
				it.fall_seen = 1'($urandom_range(1));
			end else if (roll < 12) begin
				it = echo($urandom(), $urandom(), 1'($urandom_range(1)),
					1'($urandom_range(1)), $urandom());
			end
			send_item(it);
		end
		wait_idle();
	endtask

	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic note_failure(input string what, input spb_pkg::out_item_t want,
			input spb_pkg::out_item_t got);
		bad_results++;
		if (bad_results <= REPORT_MAX)
			$display("%0t %s: expected dist %0d ok %0d zone %0d ival %0d buz %0d tog %0d,",
				$realtime, what, want.distance_q8, want.reading_ok, want.zone,
				want.beep_interval_ms, want.buzzer_level, want.toggled,
				" got dist %0d ok %0d zone %0d ival %0d buz %0d tog %0d",
				got.distance_q8, got.reading_ok, got.zone, got.beep_interval_ms,
				got.buzzer_level, got.toggled);
	endtask

	always @(posedge clk) begin
		spb_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				note_failure("unexpected result transfer", '0, out_data);
			end else begin
				want = pending_readings.pop_front();
				if (out_data.distance_q8 !== want.distance_q8
						|| out_data.reading_ok !== want.reading_ok
						|| out_data.zone !== want.zone
						|| out_data.beep_interval_ms !== want.beep_interval_ms
						|| out_data.buzzer_level !== want.buzzer_level
						|| out_data.toggled !== want.toggled)
					note_failure("result mismatch", want, out_data);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[sonar_parking_beeper_core] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = spb_pkg::CFG_SCALE;
		cfg_data = '0;
		scale_reg = spb_pkg::SCALE_RST;
		far_reg = spb_pkg::FAR_RST;
		near_reg = spb_pkg::NEAR_RST;
		mpc_reg = spb_pkg::MPC_RST;
		last_toggle = '0;
		buzzer = 1'b0;
		now_clock = 32'd1000;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_special_cases();
		test_register_corners();
		test_random_traffic(165, 26, 60);
		test_random_traffic(165, 60, 26);
		test_random_traffic(170, 0, 0);

		in_valid = 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_results == 0 && pending_readings.size() == 0)
			$display("[sonar_parking_beeper_core] OK");
		else
			$display("[sonar_parking_beeper_core] ERROR");
		$finish;
	end

endmodule
